/* rtl/lrp_pkg.sv */
// Shared types, codes and default sizes of the LR shift-reduce parser.
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned DEF_NUM_STATES      = 64;
  localparam int unsigned DEF_NUM_SYMBOLS     = 16;
  localparam int unsigned DEF_NUM_PRODUCTIONS = 32;
  localparam int unsigned DEF_STACK_DEPTH     = 128;
  localparam int unsigned DEF_MAX_REDUCTIONS  = 63;

  // Entry widths of the stores.
  localparam int unsigned ST_W   = 6;
  localparam int unsigned ACT_W  = 9;
  localparam int unsigned GOTO_W = 7;
  localparam int unsigned PROD_W = 8;

  typedef enum logic [1:0] {
    FN_PARSE  = 2'd0,
    FN_ACTION = 2'd1,
    FN_GOTO   = 2'd2,
    FN_PROD   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SHIFT  = 3'd1,
    ACT_REDUCE = 3'd2,
    ACT_ACCEPT = 3'd3,
    ACT_SR     = 3'd4,
    ACT_RR     = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    EV_SHIFT    = 3'd0,
    EV_REDUCE   = 3'd1,
    EV_ACCEPT   = 3'd2,
    EV_NOACTION = 3'd3,
    EV_NOGOTO   = 3'd4,
    EV_FAULT    = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_ACT,
    ST_PROD,
    ST_POP,
    ST_GOTO
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] state_row;
    logic [3:0] symbol;
    logic [2:0] action_kind;
    logic [5:0] target;
    logic       goto_valid;
    logic [4:0] production_slot;
    logic [3:0] lhs_symbol;
    logic [3:0] rhs_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] state_number;
    logic [4:0] production;
    logic       conflict;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

endpackage

`default_nettype wire

/* rtl/lrp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/lrp_ctrl.sv */
// Parse sequencer: table loads, clearing pass, stack bookkeeping and result generation.
`timescale 1ns / 1ps
`default_nettype none

module lrp_ctrl #(
  parameter int unsigned NUM_STATES      = lrp_pkg::DEF_NUM_STATES,
  parameter int unsigned NUM_SYMBOLS     = lrp_pkg::DEF_NUM_SYMBOLS,
  parameter int unsigned NUM_PRODUCTIONS = lrp_pkg::DEF_NUM_PRODUCTIONS,
  parameter int unsigned STACK_DEPTH     = lrp_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MAX_REDUCTIONS  = lrp_pkg::DEF_MAX_REDUCTIONS,
  localparam int unsigned RW  = $clog2(NUM_STATES),
  localparam int unsigned SW  = $clog2(NUM_SYMBOLS),
  localparam int unsigned TAW = RW + SW,
  localparam int unsigned PW  = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1,
  localparam int unsigned DW  = $clog2(STACK_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lrp_pkg::in_word_t              in_word_i,
  input  logic                           out_free_i,
  output lrp_pkg::emit_t                 emit_o,
  output logic                           act_we_o,
  output logic [TAW-1:0]                 act_waddr_o,
  output logic [lrp_pkg::ACT_W-1:0]      act_wdata_o,
  output logic                           act_re_o,
  output logic [TAW-1:0]                 act_raddr_o,
  input  logic [lrp_pkg::ACT_W-1:0]      act_rdata_i,
  output logic                           goto_we_o,
  output logic [TAW-1:0]                 goto_waddr_o,
  output logic [lrp_pkg::GOTO_W-1:0]     goto_wdata_o,
  output logic                           goto_re_o,
  output logic [TAW-1:0]                 goto_raddr_o,
  input  logic [lrp_pkg::GOTO_W-1:0]     goto_rdata_i,
  output logic                           prod_we_o,
  output logic [PW-1:0]                  prod_waddr_o,
  output logic [lrp_pkg::PROD_W-1:0]     prod_wdata_o,
  output logic                           prod_re_o,
  output logic [PW-1:0]                  prod_raddr_o,
  input  logic [lrp_pkg::PROD_W-1:0]     prod_rdata_i,
  output logic                           stk_we_o,
  output logic [DW-1:0]                  stk_waddr_o,
  output logic [lrp_pkg::ST_W-1:0]       stk_wdata_o,
  output logic                           stk_re_o,
  output logic [DW-1:0]                  stk_raddr_o,
  input  logic [lrp_pkg::ST_W-1:0]       stk_rdata_i
);

  import lrp_pkg::*;

  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RCW = $clog2(MAX_REDUCTIONS + 1);

  state_e          state_q, state_d;
  logic [TAW-1:0]  clr_q, clr_d;
  logic [ST_W-1:0] tos_q, tos_d;
  logic [CW-1:0]   count_q, count_d;
  logic [RCW-1:0]  red_q, red_d;

  // Payload of the item in work; no reset needed.
  logic [3:0]      sym_q, sym_d;
  logic [5:0]      at_q, at_d;
  logic            conf_q, conf_d;
  logic [3:0]      lhs_q, lhs_d;
  logic [ST_W-1:0] st_q, st_d;
  logic            zero_q, zero_d;

  logic            stack_reset;
  logic [2:0]      act_kind;
  logic [5:0]      act_tgt;
  logic [3:0]      p_lhs;
  logic [3:0]      p_len;
  logic [CW-1:0]   new_count;
  logic [CW-1:0]   new_top;
  logic [ST_W-1:0] popped;

  function automatic logic [TAW-1:0] tbl_addr(input logic [5:0] row, input logic [3:0] sym);
    logic [RW+5:0] r;
    logic [SW+3:0] s;
    r = {{RW{1'b0}}, row};
    s = {{SW{1'b0}}, sym};
    return {r[RW-1:0], s[SW-1:0]};
  endfunction

  function automatic out_word_t mk_res(input event_e ev, input logic [5:0] st,
                                       input logic [4:0] prod, input logic conf,
                                       input logic last);
    out_word_t w;
    w.event_res    = ev;
    w.state_number = st;
    w.production   = prod;
    w.conflict     = conf;
    w.last         = last;
    return w;
  endfunction

  assign act_kind  = act_rdata_i[8:6];
  assign act_tgt   = act_rdata_i[5:0];
  assign p_lhs     = prod_rdata_i[7:4];
  assign p_len     = prod_rdata_i[3:0];
  assign new_count = count_q - CW'(p_len);
  assign new_top   = new_count - CW'(1);
  assign popped    = zero_q ? '0 : stk_rdata_i;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    tos_d   = tos_q;
    count_d = count_q;
    red_d   = red_q;
    sym_d   = sym_q;
    at_d    = at_q;
    conf_d  = conf_q;
    lhs_d   = lhs_q;
    st_d    = st_q;
    zero_d  = zero_q;

    stack_reset  = 1'b0;
    emit_o       = '0;
    act_we_o     = 1'b0;
    act_waddr_o  = '0;
    act_wdata_o  = '0;
    act_re_o     = 1'b0;
    act_raddr_o  = '0;
    goto_we_o    = 1'b0;
    goto_waddr_o = '0;
    goto_wdata_o = '0;
    goto_re_o    = 1'b0;
    goto_raddr_o = '0;
    prod_we_o    = 1'b0;
    prod_waddr_o = '0;
    prod_wdata_o = '0;
    prod_re_o    = 1'b0;
    prod_raddr_o = '0;
    stk_we_o     = 1'b0;
    stk_waddr_o  = '0;
    stk_wdata_o  = '0;
    stk_re_o     = 1'b0;
    stk_raddr_o  = '0;

    case (state_q)
      ST_CLEAR: begin
        act_we_o     = 1'b1;
        act_waddr_o  = clr_q;
        goto_we_o    = 1'b1;
        goto_waddr_o = clr_q;
        clr_d        = clr_q + TAW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.func)
            FN_PARSE: begin
              sym_d   = in_word_i.symbol;
              red_d   = '0;
              state_d = ST_LOOK;
            end
            FN_ACTION: begin
              if (32'(in_word_i.state_row) < NUM_STATES &&
                  32'(in_word_i.symbol) < NUM_SYMBOLS) begin
                act_we_o    = 1'b1;
                act_waddr_o = tbl_addr(in_word_i.state_row, in_word_i.symbol);
                act_wdata_o = {in_word_i.action_kind, in_word_i.target};
              end
            end
            FN_GOTO: begin
              if (32'(in_word_i.state_row) < NUM_STATES &&
                  32'(in_word_i.symbol) < NUM_SYMBOLS) begin
                goto_we_o    = 1'b1;
                goto_waddr_o = tbl_addr(in_word_i.state_row, in_word_i.symbol);
                goto_wdata_o = {in_word_i.goto_valid, in_word_i.target};
              end
            end
            FN_PROD: begin
              if (32'(in_word_i.production_slot) < NUM_PRODUCTIONS) begin
                prod_we_o    = 1'b1;
                prod_waddr_o = PW'(in_word_i.production_slot);
                prod_wdata_o = {in_word_i.lhs_symbol, in_word_i.rhs_length};
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (32'(tos_q) >= NUM_STATES || 32'(sym_q) >= NUM_SYMBOLS) begin
          if (out_free_i) begin
            emit_o.valid = 1'b1;
            emit_o.word  = mk_res(EV_NOACTION, tos_q, '0, 1'b0, 1'b1);
            stack_reset  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          act_re_o    = 1'b1;
          act_raddr_o = tbl_addr(tos_q, sym_q);
          state_d     = ST_ACT;
        end
      end

      ST_ACT: begin
        case (act_kind)
          ACT_SHIFT, ACT_SR: begin
            if (out_free_i) begin
              emit_o.valid = 1'b1;
              state_d      = ST_IDLE;
              if (32'(count_q) >= STACK_DEPTH) begin
                emit_o.word = mk_res(EV_FAULT, tos_q, '0, 1'b0, 1'b1);
                stack_reset = 1'b1;
              end else begin
                emit_o.word = mk_res(EV_SHIFT, act_tgt, '0, act_kind == ACT_SR, 1'b1);
                stk_we_o    = 1'b1;
                stk_waddr_o = count_q[DW-1:0];
                stk_wdata_o = act_tgt;
                count_d     = count_q + CW'(1);
                tos_d       = act_tgt;
              end
            end
          end
          ACT_ACCEPT: begin
            if (out_free_i) begin
              emit_o.valid = 1'b1;
              emit_o.word  = mk_res(EV_ACCEPT, tos_q, '0, 1'b0, 1'b1);
              stack_reset  = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          ACT_REDUCE, ACT_RR: begin
            if (32'(red_q) >= MAX_REDUCTIONS) begin
              if (out_free_i) begin
                emit_o.valid = 1'b1;
                emit_o.word  = mk_res(EV_FAULT, tos_q, '0, 1'b0, 1'b1);
                stack_reset  = 1'b1;
                state_d      = ST_IDLE;
              end
            end else if (32'(act_tgt) >= NUM_PRODUCTIONS) begin
              if (out_free_i) begin
                emit_o.valid = 1'b1;
                emit_o.word  = mk_res(EV_NOACTION, tos_q, '0, 1'b0, 1'b1);
                stack_reset  = 1'b1;
                state_d      = ST_IDLE;
              end
            end else begin
              prod_re_o    = 1'b1;
              prod_raddr_o = PW'(act_tgt);
              at_d         = act_tgt;
              conf_d       = (act_kind == ACT_RR);
              state_d      = ST_PROD;
            end
          end
          default: begin
            if (out_free_i) begin
              emit_o.valid = 1'b1;
              emit_o.word  = mk_res(EV_NOACTION, tos_q, '0, 1'b0, 1'b1);
              stack_reset  = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
      end

      ST_PROD: begin
        if (32'(p_len) >= 32'(count_q)) begin
          if (out_free_i) begin
            emit_o.valid = 1'b1;
            emit_o.word  = mk_res(EV_FAULT, tos_q, '0, 1'b0, 1'b1);
            stack_reset  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          count_d     = new_count;
          lhs_d       = p_lhs;
          zero_d      = (new_top == '0);
          stk_re_o    = 1'b1;
          stk_raddr_o = new_top[DW-1:0];
          state_d     = ST_POP;
        end
      end

      ST_POP: begin
        st_d = popped;
        if (32'(popped) >= NUM_STATES || 32'(lhs_q) >= NUM_SYMBOLS) begin
          if (out_free_i) begin
            emit_o.valid = 1'b1;
            emit_o.word  = mk_res(EV_NOGOTO, popped, '0, 1'b0, 1'b1);
            stack_reset  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          goto_re_o    = 1'b1;
          goto_raddr_o = tbl_addr(popped, lhs_q);
          state_d      = ST_GOTO;
        end
      end

      ST_GOTO: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          if (!goto_rdata_i[6]) begin
            emit_o.word = mk_res(EV_NOGOTO, st_q, '0, 1'b0, 1'b1);
            stack_reset = 1'b1;
            state_d     = ST_IDLE;
          end else if (32'(count_q) >= STACK_DEPTH) begin
            emit_o.word = mk_res(EV_FAULT, st_q, '0, 1'b0, 1'b1);
            stack_reset = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            emit_o.word = mk_res(EV_REDUCE, goto_rdata_i[5:0], at_q[4:0], conf_q, 1'b0);
            stk_we_o    = 1'b1;
            stk_waddr_o = count_q[DW-1:0];
            stk_wdata_o = goto_rdata_i[5:0];
            count_d     = count_q + CW'(1);
            tos_d       = goto_rdata_i[5:0];
            red_d       = red_q + RCW'(1);
            state_d     = ST_LOOK;
          end
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    if (stack_reset) begin
      count_d = CW'(1);
      tos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      tos_q   <= '0;
      count_q <= CW'(1);
      red_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tos_q   <= tos_d;
      count_q <= count_d;
      red_q   <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    at_q   <= at_d;
    conf_q <= conf_d;
    lhs_q  <= lhs_d;
    st_q   <= st_d;
    zero_q <= zero_d;
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> out_free_i)
    else $error("result produced while the output register is occupied");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && 32'(count_q) <= STACK_DEPTH)
    else $error("stack count out of range");

  a_reduce_loops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid && !emit_o.word.last |=> state_q == ST_LOOK)
    else $error("reduce result not followed by a new action lookup");

  a_red_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(red_q) <= MAX_REDUCTIONS)
    else $error("reduction counter beyond its cap");

  a_stack_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stk_we_o && stk_re_o))
    else $error("stack written and read in the same cycle");

endmodule

`default_nettype wire

/* rtl/lr_shift_reduce_parser.sv */
// Top level of the table-driven LR shift-reduce parser.
`timescale 1ns / 1ps
`default_nettype none

// Table-driven LR shift-reduce parser. Input words either load a table entry (action,
// goto or production) or present one token to parse. A token runs reductions until it
// is shifted, accepted or rejected, and each shift, reduce, accept or error leaves as
// one output word; the final word of a token has last set. After an accept or any error
// the state stack returns to a single state 0. All tables and the state stack live in
// synchronous RAMs with a registered read port; the sequencer has at most one RAM read
// outstanding, so each access sees the previous write and no forwarding is needed.
// After reset the block sweeps the action and goto RAMs to "no action" and "invalid",
// one entry per cycle, over all 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entries
// (1024 with the default sizes); input is stalled during the sweep. The production
// table is not cleared, so a token must not reduce by a production never loaded.
// Steps: a load word is written while idle, and the sequencer stays idle for the next
// word. A token passes accept, action lookup and action decode, where a shift, accept or
// error is found, and each reduction adds a production read, a stack read, a goto read
// and the next action lookup. An unknown symbol or stack state is caught at the lookup,
// and a reduction that fails on the stack or the goto table ends at the production read,
// the stack read or the goto read after its action decode. A finished word sits in an
// output register, so the next input word is taken while it waits; the sequencer holds
// only when it needs to emit a second word before the first has been taken.

module lr_shift_reduce_parser #(
  parameter int unsigned NUM_STATES      = lrp_pkg::DEF_NUM_STATES,
  parameter int unsigned NUM_SYMBOLS     = lrp_pkg::DEF_NUM_SYMBOLS,
  parameter int unsigned NUM_PRODUCTIONS = lrp_pkg::DEF_NUM_PRODUCTIONS,
  parameter int unsigned STACK_DEPTH     = lrp_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MAX_REDUCTIONS  = lrp_pkg::DEF_MAX_REDUCTIONS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lrp_pkg::out_word_t out_word_o
);

  import lrp_pkg::*;

  localparam int unsigned RW  = $clog2(NUM_STATES);
  localparam int unsigned SW  = $clog2(NUM_SYMBOLS);
  localparam int unsigned TAW = RW + SW;
  localparam int unsigned PW  = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int unsigned DW  = $clog2(STACK_DEPTH);

  // Memory ports between the sequencer and the RAMs.
  logic              act_we, act_re;
  logic [TAW-1:0]    act_waddr, act_raddr;
  logic [ACT_W-1:0]  act_wdata, act_rdata;
  logic              goto_we, goto_re;
  logic [TAW-1:0]    goto_waddr, goto_raddr;
  logic [GOTO_W-1:0] goto_wdata, goto_rdata;
  logic              prod_we, prod_re;
  logic [PW-1:0]     prod_waddr, prod_raddr;
  logic [PROD_W-1:0] prod_wdata, prod_rdata;
  logic              stk_we, stk_re;
  logic [DW-1:0]     stk_waddr, stk_raddr;
  logic [ST_W-1:0]   stk_wdata, stk_rdata;

  emit_t             emit;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  // Action table: {kind, target} per (state, symbol).
  lrp_ram #(.WIDTH(ACT_W), .DEPTH(2 ** TAW)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .re_i    (act_re),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  // Goto table: {valid, state} per (state, nonterminal).
  lrp_ram #(.WIDTH(GOTO_W), .DEPTH(2 ** TAW)) u_goto_ram (
    .clk_i   (clk_i),
    .we_i    (goto_we),
    .waddr_i (goto_waddr),
    .wdata_i (goto_wdata),
    .re_i    (goto_re),
    .raddr_i (goto_raddr),
    .rdata_o (goto_rdata)
  );

  // Production table: {left-hand symbol, right-hand length}.
  lrp_ram #(.WIDTH(PROD_W), .DEPTH(NUM_PRODUCTIONS)) u_prod_ram (
    .clk_i   (clk_i),
    .we_i    (prod_we),
    .waddr_i (prod_waddr),
    .wdata_i (prod_wdata),
    .re_i    (prod_re),
    .raddr_i (prod_raddr),
    .rdata_o (prod_rdata)
  );

  // State stack. Entry zero is never written; the sequencer supplies state 0 for it.
  lrp_ram #(.WIDTH(ST_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  lrp_ctrl #(
    .NUM_STATES      (NUM_STATES),
    .NUM_SYMBOLS     (NUM_SYMBOLS),
    .NUM_PRODUCTIONS (NUM_PRODUCTIONS),
    .STACK_DEPTH     (STACK_DEPTH),
    .MAX_REDUCTIONS  (MAX_REDUCTIONS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .act_we_o     (act_we),
    .act_waddr_o  (act_waddr),
    .act_wdata_o  (act_wdata),
    .act_re_o     (act_re),
    .act_raddr_o  (act_raddr),
    .act_rdata_i  (act_rdata),
    .goto_we_o    (goto_we),
    .goto_waddr_o (goto_waddr),
    .goto_wdata_o (goto_wdata),
    .goto_re_o    (goto_re),
    .goto_raddr_o (goto_raddr),
    .goto_rdata_i (goto_rdata),
    .prod_we_o    (prod_we),
    .prod_waddr_o (prod_waddr),
    .prod_wdata_o (prod_wdata),
    .prod_re_o    (prod_re),
    .prod_raddr_o (prod_raddr),
    .prod_rdata_i (prod_rdata),
    .stk_we_o     (stk_we),
    .stk_waddr_o  (stk_waddr),
    .stk_wdata_o  (stk_wdata),
    .stk_re_o     (stk_re),
    .stk_raddr_o  (stk_raddr),
    .stk_rdata_i  (stk_rdata)
  );

  // The output register can take a new word when it is empty or is being drained now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
      out_word_d  = emit.word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

/* dv/lr_shift_reduce_parser_test.sv */
// Self-checking testbench of the table-driven LR shift-reduce parser.
`timescale 1ns / 1ps

// The bench keeps its own copy of the action, goto and production tables and of the
// state stack, and it works out the result words of every accepted token from them.
// A short directed table goes first. It covers the error codes, the conflict flags, the
// reduction cap and the table extremes. Random phases follow. Most of them load a small
// grammar of nested parentheses with freshly shuffled symbols, states and production
// slots, then parse mostly balanced sentences with it. Two sentences nest deep into the
// state stack, and at least one of them overflows it. The other phases send raw random
// words. A token is never sent while it would reduce by a production slot that has not
// been loaded. When that would happen, the slot is loaded first.
module lr_shift_reduce_parser_test;
  import lrp_pkg::*;

  localparam int unsigned N_STATES     = DEF_NUM_STATES;
  localparam int unsigned N_SYM        = DEF_NUM_SYMBOLS;
  localparam int unsigned N_PROD       = DEF_NUM_PRODUCTIONS;
  localparam int unsigned STACK_DEPTH  = DEF_STACK_DEPTH;
  localparam int unsigned MAX_RED      = DEF_MAX_REDUCTIONS;
  localparam int unsigned N_TBL        = N_STATES * N_SYM;
  localparam int unsigned RANDOM_WORDS = 400;
  // The longest token walk runs reductions up to the cap.
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_CYCLES   = 4_000_000;
  // Kind code that the action table stores but that acts as no action.
  localparam logic [2:0]  ACT_UNUSED   = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  lr_shift_reduce_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the parser tables and its state stack.
  logic [8:0] action_tbl  [N_TBL]       = '{default: '0};
  logic [6:0] goto_tbl    [N_TBL]       = '{default: '0};
  logic [7:0] prod_tbl    [N_PROD]      = '{default: '0};
  bit         prod_loaded [N_PROD]      = '{default: 1'b0};
  logic [5:0] parse_stack [STACK_DEPTH] = '{default: '0};
  int         stack_cnt                 = 1;

  out_word_t   token_events[$];    // result words of the token just worked out
  out_word_t   pending_events[$];  // result words still owed by the parser
  int unsigned words_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // Symbols, states and production slots of the current parenthesis grammar.
  logic [3:0] sym_open, sym_close, sym_end, sym_list;
  logic [5:0] q_list, q_open, q_inner, q_close;
  logic [4:0] rule_empty, rule_wrap;

  function automatic out_word_t mk_event(event_e ev, logic [5:0] st, logic [4:0] prod,
                                         bit conf, bit last);
    out_word_t r;
    r.event_res    = ev;
    r.state_number = st;
    r.production   = prod;
    r.conflict     = conf;
    r.last         = last;
    return r;
  endfunction

  // Fields that a word's function does not use carry random values.
  function automatic in_word_t noise_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t tok(logic [3:0] sym);
    in_word_t w;
    w        = noise_word();
    w.func   = FN_PARSE;
    w.symbol = sym;
    return w;
  endfunction

  function automatic in_word_t ld_act(logic [5:0] row, logic [3:0] sym, logic [2:0] kind,
                                      logic [5:0] tgt);
    in_word_t w;
    w             = noise_word();
    w.func        = FN_ACTION;
    w.state_row   = row;
    w.symbol      = sym;
    w.action_kind = kind;
    w.target      = tgt;
    return w;
  endfunction

  function automatic in_word_t ld_goto(logic [5:0] row, logic [3:0] sym, bit gv,
                                       logic [5:0] tgt);
    in_word_t w;
    w            = noise_word();
    w.func       = FN_GOTO;
    w.state_row  = row;
    w.symbol     = sym;
    w.goto_valid = gv;
    w.target     = tgt;
    return w;
  endfunction

  function automatic in_word_t ld_prod(logic [4:0] slot, logic [3:0] lhs, logic [3:0] len);
    in_word_t w;
    w                 = noise_word();
    w.func            = FN_PROD;
    w.production_slot = slot;
    w.lhs_symbol      = lhs;
    w.rhs_length      = len;
    return w;
  endfunction

  // Walks one token through the shadow tables and leaves its result words in token_events.
  // The stack is updated only when commit is set. If the walk would reduce by a slot that
  // was never loaded, it stops, names the slot, and returns 1.
  // With 6-bit states and 4-bit symbols, every state and symbol index is in range.
  function automatic bit parse_token(input logic [3:0] sym, input bit commit,
                                     output logic [4:0] missing_slot);
    logic [5:0] stk [STACK_DEPTH];
    int         cnt;
    int unsigned nred;
    logic [5:0] top;
    logic [5:0] uncovered;
    logic [8:0] ent;
    logic [5:0] tgt;
    logic [7:0] rule;
    logic [6:0] jump;
    bit         busy;
    stk          = parse_stack;
    cnt          = stack_cnt;
    nred         = 0;
    busy         = 1'b1;
    missing_slot = '0;
    token_events.delete();
    while (busy) begin
      top  = stk[cnt-1];
      ent  = action_tbl[int'(top) * N_SYM + int'(sym)];
      tgt  = ent[5:0];
      busy = 1'b0;
      case (act_e'(ent[8:6]))
        ACT_SHIFT, ACT_SR: begin
          if (cnt >= STACK_DEPTH) begin
            token_events.push_back(mk_event(EV_FAULT, top, '0, 1'b0, 1'b1));
          end else begin
            stk[cnt] = tgt;
            cnt++;
            token_events.push_back(mk_event(EV_SHIFT, tgt, '0, ent[8:6] == ACT_SR, 1'b1));
          end
        end
        ACT_ACCEPT: begin
          token_events.push_back(mk_event(EV_ACCEPT, top, '0, 1'b0, 1'b1));
        end
        ACT_REDUCE, ACT_RR: begin
          if (nred >= MAX_RED) begin
            token_events.push_back(mk_event(EV_FAULT, top, '0, 1'b0, 1'b1));
          end else if (tgt >= N_PROD) begin
            token_events.push_back(mk_event(EV_NOACTION, top, '0, 1'b0, 1'b1));
          end else if (!prod_loaded[tgt]) begin
            missing_slot = tgt[4:0];
            return 1'b1;
          end else begin
            rule = prod_tbl[tgt];
            if (int'(rule[3:0]) >= cnt) begin
              token_events.push_back(mk_event(EV_FAULT, top, '0, 1'b0, 1'b1));
            end else begin
              cnt       = cnt - int'(rule[3:0]);
              uncovered = stk[cnt-1];
              jump      = goto_tbl[int'(uncovered) * N_SYM + int'(rule[7:4])];
              if (!jump[6]) begin
                token_events.push_back(mk_event(EV_NOGOTO, uncovered, '0, 1'b0, 1'b1));
              end else if (cnt >= STACK_DEPTH) begin
                token_events.push_back(mk_event(EV_FAULT, uncovered, '0, 1'b0, 1'b1));
              end else begin
                stk[cnt] = jump[5:0];
                cnt++;
                token_events.push_back(mk_event(EV_REDUCE, jump[5:0], tgt[4:0],
                                                ent[8:6] == ACT_RR, 1'b0));
                nred++;
                busy = 1'b1;
              end
            end
          end
        end
        default: begin
          token_events.push_back(mk_event(EV_NOACTION, top, '0, 1'b0, 1'b1));
        end
      endcase
    end
    // An accept or any error leaves the stack holding state 0 alone.
    if (token_events[$].event_res != EV_SHIFT) begin
      cnt    = 1;
      stk[0] = '0;
    end
    if (commit) begin
      parse_stack = stk;
      stack_cnt   = cnt;
    end
    return 1'b0;
  endfunction

  // Applies an accepted word to the shadow state and queues the words it owes.
  function automatic void take_word(in_word_t w, bit typed, out_word_t typed_res);
    int         idx;
    logic [4:0] unused_slot;
    idx = int'(w.state_row) * N_SYM + int'(w.symbol);
    case (func_e'(w.func))
      FN_ACTION: action_tbl[idx] = {w.action_kind, w.target};
      FN_GOTO:   goto_tbl[idx]   = {w.goto_valid, w.target};
      FN_PROD: begin
        prod_tbl[w.production_slot]    = {w.lhs_symbol, w.rhs_length};
        prod_loaded[w.production_slot] = 1'b1;
      end
      default: begin
        void'(parse_token(w.symbol, 1'b1, unused_slot));
        if (typed) begin
          pending_events.push_back(typed_res);
        end else begin
          foreach (token_events[i]) pending_events.push_back(token_events[i]);
        end
      end
    endcase
  endfunction

  // Sends one word. Words go out in bursts, and a random gap may come before a new burst.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    burst_left--;
    words_sent++;
    take_word(w, typed, typed_res);
  endtask

  // Loads any production slot that the token would reach before it has been written.
  task automatic send_item(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t typed_res = '0);
    logic [4:0] slot;
    if (w.func == FN_PARSE) begin
      while (parse_token(w.symbol, 1'b0, slot)) begin
        send_word(ld_prod(slot, 4'($urandom), 4'($urandom)), 1'b0, '0);
      end
    end
    send_word(w, typed, typed_res);
  endtask

  function automatic logic [2:0] shift_kind();
    return ($urandom_range(0, 3) == 0) ? ACT_SR : ACT_SHIFT;
  endfunction

  function automatic logic [2:0] reduce_kind();
    return ($urandom_range(0, 3) == 0) ? ACT_RR : ACT_REDUCE;
  endfunction

  // Fills one row with a reduce by the same rule on each of the three terminals.
  task automatic reduce_row(input logic [5:0] row, input logic [4:0] rule);
    send_item(ld_act(row, sym_open, reduce_kind(), rule));
    send_item(ld_act(row, sym_close, reduce_kind(), rule));
    send_item(ld_act(row, sym_end, reduce_kind(), rule));
  endtask

  // SLR table of  L -> L ( L ) | empty , with an end marker accepted after L in q_list.
  // The symbol codes, state numbers and slots are drawn fresh on every load.
  task automatic load_paren_grammar();
    sym_open = 4'($urandom);
    do sym_close = 4'($urandom); while (sym_close == sym_open);
    do sym_end = 4'($urandom); while (sym_end == sym_open || sym_end == sym_close);
    sym_list = 4'($urandom);
    q_list   = 6'($urandom_range(1, 63));
    do q_open = 6'($urandom_range(1, 63)); while (q_open == q_list);
    do q_inner = 6'($urandom_range(1, 63)); while (q_inner == q_list || q_inner == q_open);
    do q_close = 6'($urandom_range(1, 63));
    while (q_close == q_list || q_close == q_open || q_close == q_inner);
    rule_empty = 5'($urandom);
    do rule_wrap = 5'($urandom); while (rule_wrap == rule_empty);

    send_item(ld_prod(rule_empty, sym_list, 4'd0));
    send_item(ld_prod(rule_wrap, sym_list, 4'd4));
    reduce_row(6'd0, rule_empty);
    send_item(ld_goto(6'd0, sym_list, 1'b1, q_list));
    send_item(ld_act(q_list, sym_end, ACT_ACCEPT, 6'($urandom)));
    send_item(ld_act(q_list, sym_open, shift_kind(), q_open));
    reduce_row(q_open, rule_empty);
    send_item(ld_goto(q_open, sym_list, 1'b1, q_inner));
    send_item(ld_act(q_inner, sym_close, shift_kind(), q_close));
    send_item(ld_act(q_inner, sym_open, shift_kind(), q_open));
    reduce_row(q_close, rule_wrap);
  endtask

  // Parses a sentence of the given number of parenthesis pairs, followed by the end
  // marker. A nested sentence opens every pair before closing any. A broken sentence has
  // one token replaced or dropped, or a stray closing parenthesis inserted.
  task automatic send_sentence(input int unsigned pairs, input bit nested, input bit broken);
    logic [3:0]  toks[$];
    int unsigned opens;
    int unsigned depth;
    int unsigned idx;
    opens = pairs;
    depth = 0;
    while (opens > 0 || depth > 0) begin
      if (opens > 0 && (nested || depth == 0 || $urandom_range(0, 1) == 1)) begin
        toks.push_back(sym_open);
        opens--;
        depth++;
      end else begin
        toks.push_back(sym_close);
        depth--;
      end
    end
    toks.push_back(sym_end);
    if (broken) begin
      idx = $urandom_range(0, toks.size() - 1);
      case ($urandom_range(0, 2))
        0:       toks[idx] = 4'($urandom);
        1:       toks.delete(idx);
        default: toks.insert(idx, sym_close);
      endcase
    end
    foreach (toks[i]) send_item(tok(toks[i]));
  endtask

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } dir_row_t;

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    int unsigned base;
    bit          deep_over_done;
    bit          deep_full_done;

    // Rows marked 1 carry the one result word that the token must give. Tokens marked 0
    // are checked against the shadow tables.
    dir_rows = '{
      // After reset the action table holds no action.
      '{tok(4'd0), 1'b1, mk_event(EV_NOACTION, 6'd0, '0, 1'b0, 1'b1)},
      '{ld_act(6'd0, 4'd15, ACT_ACCEPT, 6'd0), 1'b0, '0},
      '{tok(4'd15), 1'b1, mk_event(EV_ACCEPT, 6'd0, '0, 1'b0, 1'b1)},
      // An unused kind is stored but acts as no action.
      '{ld_act(6'd0, 4'd1, ACT_UNUSED, 6'd63), 1'b0, '0},
      '{tok(4'd1), 1'b1, mk_event(EV_NOACTION, 6'd0, '0, 1'b0, 1'b1)},
      // A reduce by a production number past the table.
      '{ld_act(6'd0, 4'd2, ACT_REDUCE, 6'd40), 1'b0, '0},
      '{tok(4'd2), 1'b1, mk_event(EV_NOACTION, 6'd0, '0, 1'b0, 1'b1)},
      // Popping fifteen entries off a one-entry stack underflows it.
      '{ld_prod(5'd31, 4'd15, 4'd15), 1'b0, '0},
      '{ld_act(6'd0, 4'd3, ACT_REDUCE, 6'd31), 1'b0, '0},
      '{tok(4'd3), 1'b1, mk_event(EV_FAULT, 6'd0, '0, 1'b0, 1'b1)},
      // An empty reduce with no goto entry for its left-hand symbol.
      '{ld_prod(5'd0, 4'd9, 4'd0), 1'b0, '0},
      '{ld_act(6'd0, 4'd4, ACT_RR, 6'd0), 1'b0, '0},
      '{tok(4'd4), 1'b1, mk_event(EV_NOGOTO, 6'd0, '0, 1'b0, 1'b1)},
      // With the goto back into state 0 the reduce repeats until the cap cuts it off.
      '{ld_goto(6'd0, 4'd9, 1'b1, 6'd0), 1'b0, '0},
      '{tok(4'd4), 1'b0, '0},
      // A shift from a conflict entry into the highest state, then nothing to do there.
      '{ld_act(6'd0, 4'd6, ACT_SR, 6'd63), 1'b0, '0},
      '{tok(4'd6), 1'b1, mk_event(EV_SHIFT, 6'd63, '0, 1'b1, 1'b1)},
      '{tok(4'd6), 1'b1, mk_event(EV_NOACTION, 6'd63, '0, 1'b0, 1'b1)},
      // Shift, then one reduce through a goto and an accept in the state it reaches.
      '{ld_act(6'd0, 4'd7, ACT_SHIFT, 6'd33), 1'b0, '0},
      '{ld_act(6'd33, 4'd8, ACT_REDUCE, 6'd0), 1'b0, '0},
      '{ld_goto(6'd33, 4'd9, 1'b1, 6'd62), 1'b0, '0},
      '{ld_act(6'd62, 4'd8, ACT_ACCEPT, 6'd0), 1'b0, '0},
      '{tok(4'd7), 1'b1, mk_event(EV_SHIFT, 6'd33, '0, 1'b0, 1'b1)},
      '{tok(4'd8), 1'b0, '0},
      // An invalid goto entry whose state bits are all set.
      '{ld_goto(6'd0, 4'd9, 1'b0, 6'd63), 1'b0, '0},
      '{tok(4'd4), 1'b1, mk_event(EV_NOGOTO, 6'd0, '0, 1'b0, 1'b1)}
    };
    deep_over_done = 1'b0;
    deep_full_done = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The parser stalls its input while it clears its tables after reset.
    foreach (dir_rows[i]) send_item(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if (!deep_over_done && words_sent - base > 40) begin
        // Sixty-four open parentheses need one push more than the stack holds.
        load_paren_grammar();
        send_sentence($urandom_range(64, 66), 1'b1, 1'b0);
        deep_over_done = 1'b1;
      end else if (!deep_full_done && words_sent - base > 200) begin
        load_paren_grammar();
        send_sentence($urandom_range(56, 63), 1'b1, 1'b0);
        deep_full_done = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        load_paren_grammar();
        repeat ($urandom_range(3, 8)) begin
          send_sentence($urandom_range(0, 6), 1'b0, $urandom_range(0, 4) == 0);
        end
      end else begin
        repeat ($urandom_range(5, 20)) send_item(noise_word());
      end
    end
    in_valid_i <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // The receiver switches between patterns: no stalls, sparse or dense random stalls, and
  // long stretches of stall.
  int unsigned stall_len  = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin : receiver_pattern
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len  = $urandom_range(8, 120);
    end else begin
      stall_len--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (stall_len % 16) >= 5;
    endcase
  end

  function automatic void report(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected ev=%0d st=%0d prod=%0d conf=%0b last=%0b, %s",
               $time, what, want.event_res, want.state_number, want.production,
               want.conflict, want.last,
               $sformatf("got ev=%0d st=%0d prod=%0d conf=%0b last=%0b",
                         got.event_res, got.state_number, got.production,
                         got.conflict, got.last));
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_word_t want;
    string     diff;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_events.size() == 0) begin
        report("result word with none pending", '0, out_word_o);
      end else begin
        want = pending_events.pop_front();
        diff = "";
        if (out_word_o.event_res !== want.event_res) diff = {diff, " event_res"};
        if (out_word_o.state_number !== want.state_number) diff = {diff, " state_number"};
        if (out_word_o.production !== want.production) diff = {diff, " production"};
        if (out_word_o.conflict !== want.conflict) diff = {diff, " conflict"};
        if (out_word_o.last !== want.last) diff = {diff, " last"};
        if (diff != "") report({"mismatch in", diff}, want, out_word_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/lrp_pkg.sv
rtl/lrp_ram.sv
rtl/lrp_ctrl.sv
rtl/lr_shift_reduce_parser.sv
dv/lr_shift_reduce_parser_test.sv
